>>> rtl/core/gisp_pkg.sv
// Shared constants for the GF(2^n) shift inner-product extractor.
package gisp_pkg;

  localparam int WORD_W            = 32;
  localparam int RESULT_W          = 16;
  localparam int FIELD_DEGREE_DEF  = 32;
  localparam int OUTPUT_BITS_DEF   = 16;
  localparam int STEPS_PER_STAGE   = 4;

  localparam logic [WORD_W-1:0] REDUCTION_RESET = 32'h04C1_1DB7;

endpackage

>>> rtl/core/gisp_stage.sv
// One pipeline stage: a few result bits and as many multiply-by-x steps.
module gisp_stage
  import gisp_pkg::*;
#(
  parameter int FIELD_DEGREE = FIELD_DEGREE_DEF,
  parameter int BASE         = 0,
  parameter int NBITS        = STEPS_PER_STAGE
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [FIELD_DEGREE-1:0] red_i,
  input  logic                    valid_i,
  input  logic [FIELD_DEGREE-1:0] cur_i,
  input  logic [FIELD_DEGREE-1:0] seed_i,
  input  logic [RESULT_W-1:0]     res_i,
  output logic                    valid_o,
  output logic [FIELD_DEGREE-1:0] cur_o,
  output logic [FIELD_DEGREE-1:0] seed_o,
  output logic [RESULT_W-1:0]     res_o
);

  logic                    valid_r;
  logic [FIELD_DEGREE-1:0] cur_r, cur_nxt;
  logic [FIELD_DEGREE-1:0] seed_r;
  logic [RESULT_W-1:0]     res_r, res_nxt;

  always_comb begin
    cur_nxt = cur_i;
    res_nxt = res_i;
    for (int j = 0; j < NBITS; j++) begin
      res_nxt[BASE+j] = ^(cur_nxt & seed_i);
      // shift up; on overflow drop the top bit and fold in the low terms
      cur_nxt = {cur_nxt[FIELD_DEGREE-2:0], 1'b0}
              ^ (cur_nxt[FIELD_DEGREE-1] ? red_i : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    seed_r <= seed_i;
    res_r  <= res_nxt;
  end

  assign valid_o = valid_r;
  assign cur_o   = cur_r;
  assign seed_o  = seed_r;
  assign res_o   = res_r;

endmodule

>>> rtl/core/gf2n_shift_inner_product_extractor.sv
// Top level of the GF(2^n) shift inner-product extractor.
//
//   channel   ports                                  handshake
//   input     in_raw_element, in_seed_element        start && !busy
//   result    out_extracted_bits                     out_valid strobe, one cycle
//   config    cfg_reduction_low_terms                cfg_valid && cfg_ready
//
// A word is taken every cycle; busy stays low. Each stage computes up to four
// result bits and as many multiply-by-x steps, the last stage only the bits
// left of min(OUTPUT_BITS,16). Reset clears the stage valid bits and loads the
// default reduction polynomial. The receiver cannot stall, so nothing is held.
module gf2n_shift_inner_product_extractor
  import gisp_pkg::*;
#(
  parameter int FIELD_DEGREE = FIELD_DEGREE_DEF,
  parameter int OUTPUT_BITS  = OUTPUT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [WORD_W-1:0]   in_raw_element,
  input  logic [WORD_W-1:0]   in_seed_element,
  output logic                out_valid,
  output logic [RESULT_W-1:0] out_extracted_bits,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [WORD_W-1:0]   cfg_reduction_low_terms
);

  localparam int RES_BITS   = (OUTPUT_BITS < RESULT_W) ? OUTPUT_BITS : RESULT_W;
  localparam int NUM_STAGES = (RES_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;

  logic [WORD_W-1:0]       red_r;
  logic [FIELD_DEGREE-1:0] red_fd;

  logic                    valid_s [NUM_STAGES+1];
  logic [FIELD_DEGREE-1:0] cur_s   [NUM_STAGES+1];
  logic [FIELD_DEGREE-1:0] seed_s  [NUM_STAGES+1];
  logic [RESULT_W-1:0]     res_s   [NUM_STAGES+1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r <= REDUCTION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      red_r <= cfg_reduction_low_terms;
    end
  end

  // bits at or above the field degree are dropped
  assign red_fd     = FIELD_DEGREE'(red_r);
  assign valid_s[0] = start && !busy;
  assign cur_s[0]   = FIELD_DEGREE'(in_raw_element);
  assign seed_s[0]  = FIELD_DEGREE'(in_seed_element);
  assign res_s[0]   = '0;

  for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
    localparam int BASE  = g * STEPS_PER_STAGE;
    localparam int LEFT  = RES_BITS - BASE;
    localparam int NBITS = (LEFT < STEPS_PER_STAGE) ? LEFT : STEPS_PER_STAGE;

    gisp_stage #(
      .FIELD_DEGREE (FIELD_DEGREE),
      .BASE         (BASE),
      .NBITS        (NBITS)
    ) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .red_i   (red_fd),
      .valid_i (valid_s[g]),
      .cur_i   (cur_s[g]),
      .seed_i  (seed_s[g]),
      .res_i   (res_s[g]),
      .valid_o (valid_s[g+1]),
      .cur_o   (cur_s[g+1]),
      .seed_o  (seed_s[g+1]),
      .res_o   (res_s[g+1])
    );
  end

  assign out_valid          = valid_s[NUM_STAGES];
  assign out_extracted_bits = res_s[NUM_STAGES];

endmodule

>>> rtl/core/gisp_checker.sv
// Port-level checks for the extractor, bound to the top level.
module gisp_checker
  import gisp_pkg::*;
#(
  parameter int LATENCY = 4
) (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic [WORD_W-1:0]   in_raw_element,
  input logic                out_valid,
  input logic [RESULT_W-1:0] out_extracted_bits
);

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    !(start && !busy) |-> ##LATENCY !out_valid)
    else $error("result without an accepted word");

  a_zero_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_raw_element == '0)) |-> ##LATENCY (out_extracted_bits == '0))
    else $error("zero raw word gave nonzero bits");

endmodule

bind gf2n_shift_inner_product_extractor gisp_checker #(
  .LATENCY (NUM_STAGES)
) u_gisp_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_raw_element     (in_raw_element),
  .out_valid          (out_valid),
  .out_extracted_bits (out_extracted_bits)
);

>>> test/gisp_extract_checker.sv
// Checker for the extractor: predicts each word's result and compares the strobed output.
module gisp_extract_checker
  import gisp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                busy,
  input  logic [WORD_W-1:0]   raw_element,
  input  logic [WORD_W-1:0]   seed_element,
  input  logic                out_valid,
  input  logic [RESULT_W-1:0] extracted_bits,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [WORD_W-1:0]   cfg_low_terms,
  output int                  fail_count,
  output int                  pending_words
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [WORD_W-1:0]   low_terms;
  logic [RESULT_W-1:0] expected_bits_q[$];

  // Bit i is the parity of (raw * x^i mod p) AND seed.
  function automatic logic [RESULT_W-1:0] inner_products(input logic [WORD_W-1:0] raw,
                                                          input logic [WORD_W-1:0] seed,
                                                          input logic [WORD_W-1:0] poly);
    logic [WORD_W-1:0]   cur;
    logic [RESULT_W-1:0] bits;
    logic                carry;
    cur  = raw;
    bits = '0;
    for (int i = 0; i < OUTPUT_BITS_DEF && i < RESULT_W; i++) begin
      bits[i] = ^(cur & seed);
      carry   = cur[FIELD_DEGREE_DEF-1];
      cur     = cur << 1;
      if (carry) begin
        cur = cur ^ poly;
      end
    end
    return bits;
  endfunction

  always @(posedge clk) begin
    logic [RESULT_W-1:0] want;
    if (!rst_n) begin
      low_terms <= REDUCTION_RESET;
      expected_bits_q.delete();
      pending_words <= 0;
    end else begin
      if (out_valid) begin
        if (expected_bits_q.size() == 0) begin
          $display("%0t: extracted_bits expected none actual %h", $time, extracted_bits);
          fail_count++;
        end else begin
          want = expected_bits_q.pop_front();
          if (extracted_bits !== want) begin
            $display("%0t: extracted_bits expected %h actual %h", $time, want,
                     extracted_bits);
            fail_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_bits_q.push_back(inner_products(raw_element, seed_element, low_terms));
      end
      if (cfg_valid && cfg_ready) begin
        low_terms <= cfg_low_terms;
      end
      // publish after the edge so readers at the next edge see a settled count
      pending_words <= expected_bits_q.size();
    end
  end

endmodule

>>> test/tb_gf2n_shift_inner_product_extractor.sv
// Top testbench for the extractor: clock, reset, stimulus and verdict.
module tb_gf2n_shift_inner_product_extractor;
  import gisp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 8;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [WORD_W-1:0]   in_raw_element = '0;
  logic [WORD_W-1:0]   in_seed_element = '0;
  logic                out_valid;
  logic [RESULT_W-1:0] out_extracted_bits;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [WORD_W-1:0]   cfg_reduction_low_terms = '0;
  int                  fail_count;
  int                  pending_words;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gf2n_shift_inner_product_extractor u_dut (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .start                   (start),
    .busy                    (busy),
    .in_raw_element          (in_raw_element),
    .in_seed_element         (in_seed_element),
    .out_valid               (out_valid),
    .out_extracted_bits      (out_extracted_bits),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_reduction_low_terms (cfg_reduction_low_terms)
  );

  gisp_extract_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .raw_element    (in_raw_element),
    .seed_element   (in_seed_element),
    .out_valid      (out_valid),
    .extracted_bits (out_extracted_bits),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_low_terms  (cfg_reduction_low_terms),
    .fail_count     (fail_count),
    .pending_words  (pending_words)
  );

  function automatic int pick_gap(input bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] pick_element();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return WORD_W'(1) << $urandom_range(0, WORD_W - 1);
      3: return $urandom() | (WORD_W'(1) << (WORD_W - 1));
      default: return $urandom();
    endcase
  endfunction

  // Present one word, hold until taken, then idle for the requested gap, if any.
  task automatic send_word(input logic [WORD_W-1:0] raw, input logic [WORD_W-1:0] seed,
                           input int gap);
    start           <= 1'b1;
    in_raw_element  <= raw;
    in_seed_element <= seed;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop start and wait until every result is in, plus pipeline slack.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending_words != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reduction(input logic [WORD_W-1:0] poly);
    drain();
    cfg_valid               <= 1'b1;
    cfg_reduction_low_terms <= poly;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_random_words(input int count);
    bit burst;
    burst = 1'b0;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      send_word(pick_element(), pick_element(), pick_gap(burst));
    end
  endtask

  initial begin
    logic [WORD_W-1:0] phase_polys[7];
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed words under the reset polynomial
    send_word('0, '0, 0);
    send_word('1, '1, 0);
    send_word('1, '0, 1);
    send_word('0, '1, 0);
    send_word(32'h8000_0000, '1, 0);
    send_word(32'h8000_0000, 32'h0000_0001, 2);
    send_word(32'h0000_0001, 32'h0000_0001, 0);
    send_word(32'h0000_0001, 32'h0000_8000, 0);
    send_word(32'h0000_0001, 32'h8000_0000, 0);
    send_word(32'hFFFF_0000, 32'h0000_FFFF, 3);
    send_word(32'hAAAA_AAAA, 32'h5555_5555, 0);
    send_word(32'h5555_5555, 32'h5555_5555, 0);
    send_word(32'hC000_0000, 32'h04C1_1DB7, 0);
    send_word(32'hF000_0001, 32'hFFFF_FFFE, 1);
    send_word(32'h7FFF_FFFF, 32'h8000_0001, 0);
    send_word(32'hDEAD_BEEF, 32'h1234_5678, 0);
    run_random_words(200);

    phase_polys = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                    $urandom(), REDUCTION_RESET, $urandom()};
    foreach (phase_polys[p]) begin
      write_reduction(phase_polys[p]);
      send_word(32'h8000_0000, '1, 0);
      send_word('1, '1, 0);
      run_random_words(170);
    end

    drain();
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
